// ===== rtl/core/bapd_pkg.sv =====
// Shared types and constants for the BLE advertising packet deframer.
// Used by the channel interfaces, the parser core and the top level.
`timescale 1ns / 1ps

package bapd_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int TYPE_W   = 3;
    localparam int LEN_W    = 6;
    localparam int ADDR_W   = 32;
    localparam int WIN_W    = 40;
    localparam int FILL_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PREAMBLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACCESS   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] PREAMBLE_RST    = 8'hAA;
    localparam logic [ADDR_W-1:0] ACCESS_ADDR_RST = 32'hD6BE898E;

    // Window fill level at which a full preamble plus address is present
    localparam logic [FILL_W-1:0] WIN_FULL = 3'd5;

    // Highest PDU type code that is accepted
    localparam logic [3:0] TYPE_MAX = 4'd6;

    // Parser phases
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR1 = 2'd1,
        PH_HDR2 = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    // Configuration register contents
    typedef struct packed {
        logic [BYTE_W-1:0] preamble;
        logic [ADDR_W-1:0] access_addr;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [TYPE_W-1:0] pdu_type;
        logic [LEN_W-1:0]  packet_length;
        logic [LEN_W-1:0]  byte_index;
        logic              is_empty;
        logic              last;
    } t_result;

endpackage

// ===== rtl/core/bapd_in_if.sv =====
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on bapd_pkg for widths.
`timescale 1ns / 1ps

interface bapd_in_if;
    logic                         valid;
    logic                         ready;
    logic [bapd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/bapd_out_if.sv =====
// Result channel: valid/ready handshake carrying one payload result word.
// Depends on bapd_pkg for widths.
`timescale 1ns / 1ps

interface bapd_out_if;
    logic                         valid;
    logic                         ready;
    logic [bapd_pkg::BYTE_W-1:0]  payload_byte;
    logic [bapd_pkg::TYPE_W-1:0]  pdu_type;
    logic [bapd_pkg::LEN_W-1:0]   packet_length;
    logic [bapd_pkg::LEN_W-1:0]   byte_index;
    logic                         is_empty;
    logic                         last;

    modport source (output valid, output payload_byte, output pdu_type,
                    output packet_length, output byte_index, output is_empty,
                    output last, input ready);
    modport sink   (input valid, input payload_byte, input pdu_type,
                    input packet_length, input byte_index, input is_empty,
                    input last, output ready);
endinterface

// ===== rtl/core/bapd_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on bapd_pkg for widths.
`timescale 1ns / 1ps

interface bapd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bapd_pkg::CFG_IDX_W-1:0] index;
    logic [bapd_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bapd_parser.sv =====
// Parser core: sliding-window sync hunt, header decode and payload counting.
// Depends on bapd_pkg for the phase enum, config and result types.
`timescale 1ns / 1ps

module bapd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bapd_pkg::BYTE_W-1:0]   i_byte,
    input  bapd_pkg::t_cfg                i_cfg,
    output logic                          o_has_result,
    output bapd_pkg::t_result             o_result
);

    bapd_pkg::t_phase                 r_phase,  n_phase;
    logic [bapd_pkg::WIN_W-1:0]       r_window, n_window;
    logic [bapd_pkg::FILL_W-1:0]      r_fill,   n_fill;
    logic [bapd_pkg::LEN_W-1:0]       r_length, n_length;
    logic [bapd_pkg::LEN_W-1:0]       r_count,  n_count;
    logic [bapd_pkg::TYPE_W-1:0]      r_type,   n_type;

    logic [bapd_pkg::WIN_W-1:0]       shifted;
    logic [bapd_pkg::FILL_W-1:0]      fill_inc;
    logic                             sync_hit;
    logic [bapd_pkg::LEN_W:0]         count_next;

    // Window after shifting in the current byte, and the sync compare.
    assign shifted  = {r_window[bapd_pkg::WIN_W-bapd_pkg::BYTE_W-1:0], i_byte};
    assign fill_inc = (r_fill < bapd_pkg::WIN_FULL) ? r_fill + 3'd1 : r_fill;
    assign sync_hit = (fill_inc == bapd_pkg::WIN_FULL)
                   && (shifted[bapd_pkg::WIN_W-1 -: bapd_pkg::BYTE_W] == i_cfg.preamble)
                   && (shifted[bapd_pkg::ADDR_W-1:0] == i_cfg.access_addr);
    assign count_next = {1'b0, r_count} + 7'd1;

    // Next state and result for one byte.
    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_fill   = r_fill;
        n_length = r_length;
        n_count  = r_count;
        n_type   = r_type;
        o_has_result           = 1'b0;
        o_result.payload_byte  = i_byte;
        o_result.pdu_type      = r_type;
        o_result.packet_length = r_length;
        o_result.byte_index    = r_count;
        o_result.is_empty      = 1'b0;
        o_result.last          = 1'b0;
        case (r_phase)
            bapd_pkg::PH_HUNT: begin
                if (sync_hit) begin
                    n_window = '0;
                    n_fill   = '0;
                    n_phase  = bapd_pkg::PH_HDR1;
                end else begin
                    n_window = shifted;
                    n_fill   = fill_inc;
                end
            end
            bapd_pkg::PH_HDR1: begin
                n_length = i_byte[bapd_pkg::LEN_W-1:0];
                n_phase  = bapd_pkg::PH_HDR2;
            end
            bapd_pkg::PH_HDR2: begin
                if (i_byte[3:0] > bapd_pkg::TYPE_MAX) begin
                    // Rejected type: resume hunting with this byte in the window.
                    n_window = {{(bapd_pkg::WIN_W-bapd_pkg::BYTE_W){1'b0}}, i_byte};
                    n_fill   = 3'd1;
                    n_phase  = bapd_pkg::PH_HUNT;
                end else begin
                    n_type  = i_byte[bapd_pkg::TYPE_W-1:0];
                    n_count = '0;
                    if (r_length == '0) begin
                        // Zero-length packet gives a single empty marker.
                        o_has_result           = 1'b1;
                        o_result.payload_byte  = '0;
                        o_result.pdu_type      = i_byte[bapd_pkg::TYPE_W-1:0];
                        o_result.byte_index    = '0;
                        o_result.is_empty      = 1'b1;
                        o_result.last          = 1'b1;
                        n_window = '0;
                        n_fill   = '0;
                        n_phase  = bapd_pkg::PH_HUNT;
                    end else begin
                        n_phase = bapd_pkg::PH_DATA;
                    end
                end
            end
            bapd_pkg::PH_DATA: begin
                o_has_result = 1'b1;
                if (count_next >= {1'b0, r_length}) begin
                    o_result.last = 1'b1;
                    n_window = '0;
                    n_fill   = '0;
                    n_count  = '0;
                    n_phase  = bapd_pkg::PH_HUNT;
                end else begin
                    n_count = count_next[bapd_pkg::LEN_W-1:0];
                end
            end
            default: begin
                n_phase = bapd_pkg::PH_HUNT;
            end
        endcase
    end

    // State registers advance only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bapd_pkg::PH_HUNT;
            r_window <= '0;
            r_fill   <= '0;
            r_length <= '0;
            r_count  <= '0;
            r_type   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_fill   <= n_fill;
            r_length <= n_length;
            r_count  <= n_count;
            r_type   <= n_type;
        end
    end

    // The payload counter never reaches the held length while in payload.
    a_count_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bapd_pkg::PH_DATA) |-> (r_count < r_length))
        else $error("payload counter reached packet length");

    // A final result sends the parser back to hunting with an empty window.
    a_last_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_has_result && o_result.last)
            |=> (r_phase == bapd_pkg::PH_HUNT && r_fill == '0 && r_count == '0))
        else $error("parser did not return to hunt after last result");

    // The window fill level saturates at a full window.
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= bapd_pkg::WIN_FULL)
        else $error("window fill exceeded five bytes");

    // Results only come out of the second header byte or the payload.
    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result |-> (r_phase == bapd_pkg::PH_DATA || r_phase == bapd_pkg::PH_HDR2))
        else $error("result produced outside header or payload phase");

endmodule

// ===== rtl/core/ble_adv_packet_deframer.sv =====
// Top level of the BLE advertising packet deframer: input register,
// configuration registers, parser core and output register.
// Depends on bapd_pkg, the three channel interfaces and bapd_parser.
//
// Channel   Direction  Word                       Handshake
// i_in      in         in_byte (8)                valid/ready
// o_out     out        payload result (25 bits)   valid/ready
// i_cfg     in         index (1), data (32)       valid/ready, always ready
//
// One byte is processed per cycle while the output register is free or drains;
// the byte is held in the input register and its result word in the output register.
// Reset (synchronous, active low) returns the parser to hunting with an
// empty window and restores the default preamble and access address.
// A stalled output holds its word while the input register still takes one
// more byte; input ready falls only when both registers are occupied.
`timescale 1ns / 1ps

module ble_adv_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bapd_in_if.sink     i_in,
    bapd_out_if.source  o_out,
    bapd_cfg_if.sink    i_cfg
);

    logic                         r_in_valid;
    logic [bapd_pkg::BYTE_W-1:0]  r_in_byte;
    logic                         r_out_valid;
    bapd_pkg::t_result            r_out;
    bapd_pkg::t_cfg               r_cfg;

    logic                         step;
    logic                         has_result;
    bapd_pkg::t_result            result;

    // The held byte moves on whenever the output register is free or drains.
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign i_cfg.ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble    <= bapd_pkg::PREAMBLE_RST;
            r_cfg.access_addr <= bapd_pkg::ACCESS_ADDR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bapd_pkg::CFG_IDX_PREAMBLE: begin
                    r_cfg.preamble <= i_cfg.data[bapd_pkg::BYTE_W-1:0];
                end
                bapd_pkg::CFG_IDX_ACCESS: begin
                    r_cfg.access_addr <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    bapd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.pdu_type      = r_out.pdu_type;
    assign o_out.packet_length = r_out.packet_length;
    assign o_out.byte_index    = r_out.byte_index;
    assign o_out.is_empty      = r_out.is_empty;
    assign o_out.last          = r_out.last;

    // A held byte is never lost: it stays until the parser takes it.
    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte dropped before processing");

    // A result is only written over once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_out_valid) |-> o_out.ready)
        else $error("output register overwritten while still valid");

    // Input ready only falls when both stages hold a word.
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule
